// File: design/ddo_pkg.sv
package ddo_pkg;

    localparam int POS_W     = 32;
    localparam int HEAD_W    = 19;
    localparam int DELTA_W   = 16;
    localparam int REG_W     = 16;
    localparam int WRAP_W    = 35;
    localparam int WRAP_STEPS = 15;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W    = 17;

    localparam logic [WRAP_W-1:0] PI_Q16      = WRAP_W'(205887);
    localparam logic [WRAP_W-1:0] TWO_PI_Q16  = WRAP_W'(411775);
    localparam logic [WRAP_W-1:0] WRAP_OFFSET = WRAP_W'(411775) << (WRAP_STEPS - 1);
    localparam logic signed [20:0] PI_Z       = 21'sd205887;
    localparam logic signed [20:0] HALF_PI_Z  = 21'sd102944;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic REG_DIST_PER_DEG = 1'b0;
    localparam logic REG_INV_TRACK    = 1'b1;

    localparam logic [REG_W-1:0] DIST_PER_DEG_RESET = 16'd4003;
    localparam logic [REG_W-1:0] INV_TRACK_RESET    = 16'd4681;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_TURN_LD,
        S_TURN,
        S_WRAP_LD,
        S_WRAP,
        S_CORD_LD,
        S_CORDIC,
        S_MOVE_LD,
        S_MOVE,
        S_UPD
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 17'd51472;
            5'd1:  v = 17'd30386;
            5'd2:  v = 17'd16055;
            5'd3:  v = 17'd8150;
            5'd4:  v = 17'd4091;
            5'd5:  v = 17'd2047;
            5'd6:  v = 17'd1024;
            5'd7:  v = 17'd512;
            5'd8:  v = 17'd256;
            5'd9:  v = 17'd128;
            5'd10: v = 17'd64;
            5'd11: v = 17'd32;
            5'd12: v = 17'd16;
            5'd13: v = 17'd8;
            5'd14: v = 17'd4;
            5'd15: v = 17'd2;
            5'd16: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// File: design/ddo_smul.sv
module ddo_smul #(
    parameter int AW = 16,
    parameter int BW = 16,
    parameter bit B_SIGNED = 1'b0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ddo_pkg::t_mul_ctl           i_ctl,
    input  logic signed [AW-1:0]        i_a,
    input  logic [BW-1:0]               i_b,
    output logic signed [AW+BW-1:0]     o_prod
);
    localparam int PW = AW + BW;
    localparam int IW = $clog2(BW);

    logic signed [PW-1:0] r_a;
    logic [BW-1:0]        r_b;
    logic signed [PW-1:0] r_acc;
    logic [IW-1:0]        r_idx;
    logic                 last;

    assign last = (r_idx == IW'(BW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctl.load) begin
            r_idx <= '0;
        end else if (i_ctl.step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // one multiplier bit per cycle while step is high, sign bit weighs negative when signed
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a   <= {{BW{i_a[AW-1]}}, i_a};
            r_b   <= i_b;
            r_acc <= '0;
        end else if (i_ctl.step) begin
            if (r_b[0]) begin
                if (B_SIGNED && last) begin
                    r_acc <= r_acc - r_a;
                end else begin
                    r_acc <= r_acc + r_a;
                end
            end
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_prod = r_acc;
endmodule

// File: design/differential_drive_odometry.sv
// one request is processed at a time by the bit-serial multipliers (16 + 16 + 32 steps),
//   the 15-step heading wrap and the CORDIC loop; a new request is accepted only after
//   the previous result has been loaded into the output register
// a finished result waits in the output register while the next item is accepted
// reset (synchronous, active low) clears the pose and restores both registers
module differential_drive_odometry #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_left_delta,
    input  logic signed [15:0] i_right_delta,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic signed [18:0] o_pose_heading
);
    localparam int MAX_STEPS = (CORDIC_ITERATIONS > 32) ? CORDIC_ITERATIONS : 32;
    localparam int CNT_W = $clog2(MAX_STEPS);
    localparam int WW = ddo_pkg::WRAP_W;

    ddo_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             cnt_clr;

    logic [15:0] r_dist_per_deg, r_inv_track;

    ddo_pkg::t_mul_ctl ctl_mul1, ctl_turn, ctl_move;

    logic signed [31:0] prod_l, prod_r;
    logic signed [48:0] prod_turn;
    logic signed [63:0] prod_mx, prod_my;

    logic signed [31:0] r_travel;
    logic signed [32:0] diff_lr;
    logic [WW-1:0] r_rem_nh, r_rem_mid, r_div;
    logic signed [18:0] r_nh;
    logic signed [33:0] r_cx, r_cy;
    logic signed [20:0] r_cz;
    logic               r_flip;
    logic signed [31:0] sin_op, cos_op;
    logic signed [31:0] r_pos_x, r_pos_y;
    logic signed [18:0] r_heading;
    logic               r_ovalid;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ddo_pkg::REG_INV_TRACK) ? {16'd0, r_inv_track}
                                                          : {16'd0, r_dist_per_deg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_per_deg <= ddo_pkg::DIST_PER_DEG_RESET;
            r_inv_track    <= ddo_pkg::INV_TRACK_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                ddo_pkg::REG_DIST_PER_DEG: r_dist_per_deg <= pwdata[15:0];
                ddo_pkg::REG_INV_TRACK:    r_inv_track    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ddo_pkg::S_IDLE:    if (i_valid) n_state = ddo_pkg::S_MUL1;
            ddo_pkg::S_MUL1:    if (r_cnt == CNT_W'(15)) n_state = ddo_pkg::S_TURN_LD;
            ddo_pkg::S_TURN_LD: n_state = ddo_pkg::S_TURN;
            ddo_pkg::S_TURN:    if (r_cnt == CNT_W'(15)) n_state = ddo_pkg::S_WRAP_LD;
            ddo_pkg::S_WRAP_LD: n_state = ddo_pkg::S_WRAP;
            ddo_pkg::S_WRAP: begin
                if (r_cnt == CNT_W'(ddo_pkg::WRAP_STEPS - 1)) n_state = ddo_pkg::S_CORD_LD;
            end
            ddo_pkg::S_CORD_LD: n_state = ddo_pkg::S_CORDIC;
            ddo_pkg::S_CORDIC: begin
                if (r_cnt == CNT_W'(CORDIC_ITERATIONS - 1)) n_state = ddo_pkg::S_MOVE_LD;
            end
            ddo_pkg::S_MOVE_LD: n_state = ddo_pkg::S_MOVE;
            ddo_pkg::S_MOVE:    if (r_cnt == CNT_W'(31)) n_state = ddo_pkg::S_UPD;
            ddo_pkg::S_UPD:     if (!r_ovalid || i_ready) n_state = ddo_pkg::S_IDLE;
            default:            n_state = ddo_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready  = 1'b0;
        cnt_clr  = 1'b0;
        ctl_mul1 = '0;
        ctl_turn = '0;
        ctl_move = '0;
        case (r_state)
            ddo_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                cnt_clr       = 1'b1;
                ctl_mul1.load = 1'b1;
            end
            ddo_pkg::S_MUL1:    ctl_mul1.step = 1'b1;
            ddo_pkg::S_TURN_LD: begin
                cnt_clr       = 1'b1;
                ctl_turn.load = 1'b1;
            end
            ddo_pkg::S_TURN:    ctl_turn.step = 1'b1;
            ddo_pkg::S_WRAP_LD: cnt_clr = 1'b1;
            ddo_pkg::S_CORD_LD: cnt_clr = 1'b1;
            ddo_pkg::S_MOVE_LD: begin
                cnt_clr       = 1'b1;
                ctl_move.load = 1'b1;
            end
            ddo_pkg::S_MOVE:    ctl_move.step = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= cnt_clr ? '0 : r_cnt + 1'b1;
        end
    end

    ddo_smul #(.AW(16), .BW(16), .B_SIGNED(1'b0)) u_mul_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_mul1),
        .i_a(i_left_delta), .i_b(r_dist_per_deg), .o_prod(prod_l));

    ddo_smul #(.AW(16), .BW(16), .B_SIGNED(1'b0)) u_mul_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_mul1),
        .i_a(i_right_delta), .i_b(r_dist_per_deg), .o_prod(prod_r));

    assign diff_lr = 33'(prod_r) - 33'(prod_l);

    ddo_smul #(.AW(33), .BW(16), .B_SIGNED(1'b0)) u_mul_turn (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_turn),
        .i_a(diff_lr), .i_b(r_inv_track), .o_prod(prod_turn));

    ddo_smul #(.AW(32), .BW(32), .B_SIGNED(1'b1)) u_mul_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_move),
        .i_a(r_travel), .i_b(sin_op), .o_prod(prod_mx));

    ddo_smul #(.AW(32), .BW(32), .B_SIGNED(1'b1)) u_mul_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_move),
        .i_a(r_travel), .i_b(cos_op), .o_prod(prod_my));

    // datapath
    logic signed [32:0] sum_lr;
    logic signed [32:0] turn;
    logic signed [WW-1:0] init_nh, init_mid;
    logic signed [20:0] mid, nh_wide;
    logic signed [33:0] cdx, cdy;
    logic signed [20:0] catan;
    logic signed [33:0] move_x, move_y;
    logic signed [34:0] next_x, next_y;

    assign sum_lr   = 33'(prod_l) + 33'(prod_r);
    assign turn     = prod_turn[48:16];
    // offset by a multiple of two pi keeps the remainder input non-negative
    assign init_nh  = WW'(r_heading) + WW'(turn) + $signed(ddo_pkg::PI_Q16)
                    + $signed(ddo_pkg::WRAP_OFFSET);
    assign init_mid = WW'(r_heading) + WW'(turn >>> 1) + $signed(ddo_pkg::PI_Q16)
                    + $signed(ddo_pkg::WRAP_OFFSET);
    assign mid      = $signed(21'(r_rem_mid)) - ddo_pkg::PI_Z;
    assign nh_wide  = $signed(21'(r_rem_nh)) - ddo_pkg::PI_Z;
    assign cdx      = r_cy >>> r_cnt;
    assign cdy      = r_cx >>> r_cnt;
    assign catan    = $signed(21'(ddo_pkg::atan_q16(ddo_pkg::ATAN_IDX_W'(r_cnt))));
    assign move_x   = prod_mx[63:30];
    assign move_y   = prod_my[63:30];
    assign next_x   = 35'(r_pos_x) - 35'(move_x);
    assign next_y   = 35'(r_pos_y) + 35'(move_y);

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] res;
        if (v > 35'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -35'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        case (r_state)
            ddo_pkg::S_TURN_LD: r_travel <= sum_lr[32:1];
            ddo_pkg::S_WRAP_LD: begin
                r_rem_nh  <= init_nh;
                r_rem_mid <= init_mid;
                r_div     <= ddo_pkg::WRAP_OFFSET;
            end
            ddo_pkg::S_WRAP: begin
                // restoring remainder, one quotient bit per cycle
                if (r_rem_nh >= r_div) r_rem_nh <= r_rem_nh - r_div;
                if (r_rem_mid >= r_div) r_rem_mid <= r_rem_mid - r_div;
                r_div <= r_div >> 1;
            end
            ddo_pkg::S_CORD_LD: begin
                r_nh <= nh_wide[18:0];
                r_cx <= ddo_pkg::CORDIC_GAIN;
                r_cy <= '0;
                if (mid > ddo_pkg::HALF_PI_Z) begin
                    r_cz   <= mid - ddo_pkg::PI_Z;
                    r_flip <= 1'b1;
                end else if (mid < -ddo_pkg::HALF_PI_Z) begin
                    r_cz   <= mid + ddo_pkg::PI_Z;
                    r_flip <= 1'b1;
                end else begin
                    r_cz   <= mid;
                    r_flip <= 1'b0;
                end
            end
            ddo_pkg::S_CORDIC: begin
                if (r_cz >= 0) begin
                    r_cx <= r_cx - cdx;
                    r_cy <= r_cy + cdy;
                    r_cz <= r_cz - catan;
                end else begin
                    r_cx <= r_cx + cdx;
                    r_cy <= r_cy - cdy;
                    r_cz <= r_cz + catan;
                end
            end
            ddo_pkg::S_MOVE_LD: ;
            default: ;
        endcase
    end

    // trig operands settle at the end of the cordic loop, ahead of the move load
    assign sin_op = r_flip ? 32'(-r_cy) : 32'(r_cy);
    assign cos_op = r_flip ? 32'(-r_cx) : 32'(r_cx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_state == ddo_pkg::S_UPD && (!r_ovalid || i_ready)) begin
                r_pos_x   <= sat32(next_x);
                r_pos_y   <= sat32(next_y);
                r_heading <= r_nh;
                r_ovalid  <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_pose_x       = r_pos_x;
    assign o_pose_y       = r_pos_y;
    assign o_pose_heading = r_heading;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ddo_pkg::S_IDLE) |-> !o_ready)
        else $error("input ready while busy");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ddo_pkg::S_MUL1))
        else $error("accepted request did not start multiply");

    a_result_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ddo_pkg::S_UPD))
        else $error("result valid without update");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_heading <= 19'sd205887) && (r_heading >= -19'sd205887))
        else $error("heading out of wrap range");
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int ITER       = 16;
    localparam int LATENCY    = 85 + ITER;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [18:0] heading;
    } t_pose;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_left_delta = '0;
    logic signed [15:0] i_right_delta = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_pose_x;
    logic signed [31:0] o_pose_y;
    logic signed [18:0] o_pose_heading;

    t_pose  expected_poses[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;
    longint dist_per_deg = 4003;
    longint inv_track = 4681;
    longint cur_x = 0;
    longint cur_y = 0;
    longint cur_heading = 0;

    differential_drive_odometry #(.CORDIC_ITERATIONS(ITER)) u_top (.*);

    always #4 i_clk = ~i_clk;

    function automatic longint wrap_pi(input longint v);
        longint r;
        r = (v + 205887) % 411775;
        if (r < 0) r += 411775;
        return r - 205887;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_entry(input int i);
        longint tbl[17];
        tbl = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? tbl[i] : 0;
    endfunction

    // advances the tracked pose by one wheel request and returns the new pose
    function automatic t_pose advance_pose(input logic signed [15:0] l_deg,
                                           input logic signed [15:0] r_deg);
        longint l, r, travel, turn, mid, nh, cx, cy, z, dx, dy, s, c;
        bit     flip;
        t_pose  p;
        l = longint'(l_deg) * dist_per_deg;
        r = longint'(r_deg) * dist_per_deg;
        travel = (l + r) >>> 1;
        turn = ((r - l) * inv_track) >>> 16;
        mid = wrap_pi(cur_heading + (turn >>> 1));
        nh = wrap_pi(cur_heading + turn);
        z = mid;
        flip = 1'b0;
        // fold outer quadrants onto the inner half, negate afterwards
        if (z > 102944) begin
            z -= 205887;
            flip = 1'b1;
        end else if (z < -102944) begin
            z += 205887;
            flip = 1'b1;
        end
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < ITER; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx;
                cy += dy;
                z -= atan_entry(i);
            end else begin
                cx += dx;
                cy -= dy;
                z += atan_entry(i);
            end
        end
        s = flip ? -cy : cy;
        c = flip ? -cx : cx;
        cur_x = clamp32(cur_x - ((travel * s) >>> 30));
        cur_y = clamp32(cur_y + ((travel * c) >>> 30));
        cur_heading = nh;
        p.x = cur_x[31:0];
        p.y = cur_y[31:0];
        p.heading = nh[18:0];
        return p;
    endfunction

    // receiver stall pattern, steps through four ready modes in turn
    int rx_cycle = 0;
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 150) % 4)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ($urandom_range(0, 5) == 0);
            default: i_ready <= ((rx_cycle % 7) < 4);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_poses.size() == 0) begin
                $display("%0t: unexpected pose x=%0d y=%0d h=%0d", $time,
                         o_pose_x, o_pose_y, o_pose_heading);
                errors++;
            end else begin
                t_pose e;
                e = expected_poses.pop_front();
                if (o_pose_x !== e.x) begin
                    $display("%0t: pose_x expected %0d actual %0d", $time, e.x, o_pose_x);
                    errors++;
                end
                if (o_pose_y !== e.y) begin
                    $display("%0t: pose_y expected %0d actual %0d", $time, e.y, o_pose_y);
                    errors++;
                end
                if (o_pose_heading !== e.heading) begin
                    $display("%0t: pose_heading expected %0d actual %0d", $time,
                             e.heading, o_pose_heading);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] value);
        logic [31:0] rd;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == ddo_pkg::REG_DIST_PER_DEG) dist_per_deg = value[15:0];
        else inv_track = value[15:0];
        // read back
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[15:0] !== value[15:0]) begin
            $display("%0t: register %0d expected %0d actual %0d", $time, idx,
                     value[15:0], rd[15:0]);
            errors++;
        end
    endtask

    task automatic send_request(input logic signed [15:0] l, input logic signed [15:0] r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 20);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_left_delta <= l;
        i_right_delta <= r;
        do @(posedge i_clk); while (!o_ready);
        expected_poses.push_back(advance_pose(l, r));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        wait (expected_poses.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(16'sd0, 16'sd0);
        send_request(16'sd32767, 16'sd32767);
        send_request(-16'sd32768, -16'sd32768);
        send_request(16'sd32767, -16'sd32768);
        send_request(-16'sd32768, 16'sd32767);
        send_request(16'sd1, -16'sd1);
        send_request(-16'sd1, 16'sd0);
        send_request(16'sd360, 16'sd720);
        wait_drained();
        // largest scale: drive the pose into saturation and wrap the heading hard
        reg_write(ddo_pkg::REG_DIST_PER_DEG, 32'hFFFF_FFFF);
        reg_write(ddo_pkg::REG_INV_TRACK, 32'hABCD_FFFF);
        repeat (3) send_request(16'sd32767, 16'sd32767);
        repeat (3) send_request(-16'sd32768, -16'sd32768);
        send_request(-16'sd32768, 16'sd32767);
        send_request(16'sd32767, 16'sd0);
        send_request(16'sd0, 16'sd32767);
        send_request(-16'sd32768, 16'sd0);
        wait_drained();
        reg_write(ddo_pkg::REG_DIST_PER_DEG, 32'h0);
        reg_write(ddo_pkg::REG_INV_TRACK, 32'h0);
        send_request(16'sd32767, -16'sd32768);
        send_request(-16'sd5, 16'sd9);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic signed [15:0] l, r;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                l = 16'($urandom);
                r = 16'($urandom);
            end else begin
                l = 16'($signed($urandom_range(0, 1000)) - 500);
                r = 16'($signed($urandom_range(0, 1000)) - 500);
            end
            send_request(l, r);
            if (i == count / 2) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        reg_write(ddo_pkg::REG_DIST_PER_DEG, 32'd4003);
        reg_write(ddo_pkg::REG_INV_TRACK, 32'd4681);
        test_random(110);
        reg_write(ddo_pkg::REG_DIST_PER_DEG, 32'hFFFF);
        reg_write(ddo_pkg::REG_INV_TRACK, 32'hFFFF);
        test_random(100);
        reg_write(ddo_pkg::REG_DIST_PER_DEG, $urandom);
        reg_write(ddo_pkg::REG_INV_TRACK, $urandom);
        test_random(110);
        reg_write(ddo_pkg::REG_DIST_PER_DEG, 32'd1);
        reg_write(ddo_pkg::REG_INV_TRACK, 32'd1);
        test_random(110);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
